/* sv/smas_pkg.sv */
// ----------------------------------------------------------------------------
// smas_pkg
// Shared types for the standardized max-abs statistic block.
// ----------------------------------------------------------------------------
package smas_pkg;

    // Handshake status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;   // iterating
        logic done;   // one-cycle pulse, result valid from this cycle on
    } smas_unit_status_t;

endpackage

/* sv/smas_cfg.sv */
// ----------------------------------------------------------------------------
// smas_cfg
// APB-style configuration registers: variance tolerance and absolute mode.
// ----------------------------------------------------------------------------
module smas_cfg #(
    parameter int DATA_WIDTH = 32,
    parameter int PDATA_W    = 32,
    parameter int PADDR_W    = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    output logic [DATA_WIDTH-1:0] tolerance,
    output logic                  abs_mode
);

    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_ABS_MODE  = 1'b1;

    logic [DATA_WIDTH-1:0] tol_reg, tol_next;
    logic                  abs_reg, abs_next;
    logic                  wr_en;
    logic                  reg_idx;

    // register index sits above the byte offset of one data word
    assign reg_idx = paddr[PADDR_W-1];
    assign wr_en   = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    always_comb begin
        tol_next = tol_reg;
        abs_next = abs_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_TOLERANCE: tol_next = pwdata[DATA_WIDTH-1:0];
                REG_ABS_MODE:  abs_next = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TOLERANCE: prdata = PDATA_W'(tol_reg);
            REG_ABS_MODE:  prdata = PDATA_W'(abs_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
            abs_reg <= 1'b0;
        end else begin
            tol_reg <= tol_next;
            abs_reg <= abs_next;
        end
    end

    assign tolerance = tol_reg;
    assign abs_mode  = abs_reg;

endmodule

/* sv/smas_isqrt.sv */
// ----------------------------------------------------------------------------
// smas_isqrt
// Restoring integer square root of (radicand << FRAC_BITS), two radicand bits
// shifted in per cycle, one root bit out per cycle.
// ----------------------------------------------------------------------------
module smas_isqrt #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     start,
    input  logic [DATA_WIDTH-1:0]                    radicand,
    output logic [(DATA_WIDTH+FRAC_BITS+1)/2-1:0]    root,
    output smas_pkg::smas_unit_status_t              status
);

    localparam int RW    = (DATA_WIDTH + FRAC_BITS + 1) / 2;
    localparam int RAD_W = 2 * RW;
    localparam int CW    = $clog2(RW + 1);

    logic [RAD_W-1:0] rad_reg, rad_next;
    logic [RW+1:0]    rem_reg, rem_next;
    logic [RW-1:0]    root_reg, root_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [RW+1:0]    shifted;
    logic [RW+1:0]    trial;
    logic [RW+2:0]    diff;
    logic             ge;

    // remainder stays below 2^RW until the final step
    assign shifted = {rem_reg[RW-1:0], rad_reg[RAD_W-1 -: 2]};
    assign trial   = {root_reg, 2'b01};
    assign diff    = {1'b0, shifted} - {1'b0, trial};
    assign ge      = ~diff[RW+2];

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = RAD_W'(radicand) << FRAC_BITS;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(RW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next  = rad_reg << 2;
            rem_next  = ge ? diff[RW+1:0] : shifted;
            root_next = {root_reg[RW-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* sv/smas_divider.sv */
// ----------------------------------------------------------------------------
// smas_divider
// Restoring divider for (magnitude << FRAC_BITS) / root, one quotient bit per
// cycle. Keeps DATA_WIDTH quotient bits plus a sticky overflow flag.
// ----------------------------------------------------------------------------
module smas_divider #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     start,
    input  logic [DATA_WIDTH-1:0]                    magnitude,
    input  logic [(DATA_WIDTH+FRAC_BITS+1)/2-1:0]    divisor,
    output logic [DATA_WIDTH-1:0]                    quotient,
    output logic                                     overflow,
    output smas_pkg::smas_unit_status_t              status
);

    localparam int RW = (DATA_WIDTH + FRAC_BITS + 1) / 2;
    localparam int NW = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]         dvd_reg, dvd_next;
    logic [RW-1:0]         dvs_reg, dvs_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] q_reg, q_next;
    logic                  ovf_reg, ovf_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [RW:0]           shifted;
    logic [RW+1:0]         diff;
    logic                  qbit;

    assign shifted = {rem_reg, dvd_reg[NW-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};
    assign qbit    = ~diff[RW+1];

    always_comb begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = NW'(magnitude) << FRAC_BITS;
            dvs_next  = divisor;
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next  = dvd_reg << 1;
            // after a successful subtract the remainder is below the divisor
            rem_next  = qbit ? diff[RW-1:0] : shifted[RW-1:0];
            ovf_next  = ovf_reg | q_reg[DATA_WIDTH-1];
            q_next    = {q_reg[DATA_WIDTH-2:0], qbit};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign quotient    = q_reg;
    assign overflow    = ovf_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* sv/standardized_max_abs_statistic_top.sv */
// ----------------------------------------------------------------------------
// standardized_max_abs_statistic_top
// Standardized score (statistic - expectation) / sqrt(variance) per element,
// saturated, with a running maximum of the absolute score per vector.
// ----------------------------------------------------------------------------
// One element is processed at a time. An element whose variance is above the
// tolerance (Q16.16 with the default parameters) passes through the
// bit-serial square root, which takes two radicand bits per cycle, and then
// the restoring divider, which takes one quotient bit per cycle. An element
// at or below the tolerance skips both units. Results sit in an output
// register, so the next element is taken while the previous result waits;
// only a second finished result stalls behind an untaken one. The maximum
// is cleared once the element marked last has been processed.
module standardized_max_abs_statistic_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input transactions
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_statistic,
    input  logic signed [DATA_WIDTH-1:0] s_expectation,
    input  logic [DATA_WIDTH-1:0]        s_variance,
    input  logic                         s_last_element,
    // result transactions
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_score,
    output logic [DATA_WIDTH-2:0]        m_running_max_abs,
    output logic                         m_last_result,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [((DATA_WIDTH > 32) ? 4 : 3)-1:0] paddr,
    input  logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] prdata,
    output logic                                   pready
);

    localparam int W       = DATA_WIDTH;
    localparam int RW      = (DATA_WIDTH + FRAC_BITS + 1) / 2;
    localparam int PDATA_W = (DATA_WIDTH > 32) ? 64 : 32;
    localparam int PADDR_W = (DATA_WIDTH > 32) ? 4 : 3;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SQRT   = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [W-1:0] SBIT = {1'b1, {(W-1){1'b0}}};

    logic [1:0]       state_reg, state_next;

    // element context held for the whole transaction
    logic [W-1:0]     mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic             bypass_reg, bypass_next;
    logic             last_reg, last_next;

    logic [W-2:0]     max_reg, max_next;

    logic             out_valid_reg, out_valid_next;
    logic [W-1:0]     out_score_reg, out_score_next;
    logic [W-2:0]     out_max_reg, out_max_next;
    logic             out_last_reg, out_last_next;

    logic [W-1:0]     tolerance;
    logic             abs_mode;

    logic             accept;
    logic             above_tol;
    logic signed [W:0] diff_in;
    logic [W:0]       diff_neg;
    logic             sq_start;
    logic             dv_start;
    logic [RW-1:0]    root;
    logic [W-1:0]     quot;
    logic             quot_ovf;
    smas_pkg::smas_unit_status_t sq_st;
    smas_pkg::smas_unit_status_t dv_st;

    logic             load_out;
    logic             q_big;
    logic             q_gt_sbit;
    logic [W-2:0]     abs_q;
    logic [W-1:0]     sat_q;
    logic [W-1:0]     score_val;
    logic [W-2:0]     max_upd;

    smas_cfg #(
        .DATA_WIDTH (DATA_WIDTH),
        .PDATA_W    (PDATA_W),
        .PADDR_W    (PADDR_W)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .tolerance (tolerance),
        .abs_mode  (abs_mode)
    );

    smas_isqrt #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (s_variance),
        .root     (root),
        .status   (sq_st)
    );

    smas_divider #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (dv_start),
        .magnitude (mag_reg),
        .divisor   (root),
        .quotient  (quot),
        .overflow  (quot_ovf),
        .status    (dv_st)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid & s_ready;
    assign above_tol = (s_variance > tolerance);
    assign diff_in   = {s_statistic[W-1], s_statistic} - {s_expectation[W-1], s_expectation};
    assign diff_neg  = ~diff_in + 1'b1;
    assign sq_start  = accept & above_tol;
    assign dv_start  = (state_reg == ST_SQRT) & sq_st.done;
    assign load_out  = (state_reg == ST_FINISH) & (~out_valid_reg | m_ready);

    // saturation of the quotient
    assign q_big     = quot_ovf | quot[W-1];
    assign q_gt_sbit = quot_ovf | (quot[W-1] & (|quot[W-2:0]));
    assign abs_q     = q_big ? {(W-1){1'b1}} : quot[W-2:0];
    assign sat_q     = q_gt_sbit ? SBIT : quot;

    always_comb begin
        if (bypass_reg) begin
            score_val = '0;
        end else if (!abs_mode && neg_reg) begin
            score_val = ~sat_q + 1'b1;
        end else begin
            score_val = {1'b0, abs_q};
        end
    end

    assign max_upd = (!bypass_reg && (abs_q > max_reg)) ? abs_q : max_reg;

    always_comb begin
        state_next  = state_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        bypass_next = bypass_reg;
        last_next   = last_reg;
        max_next    = max_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    neg_next    = diff_in[W];
                    mag_next    = diff_in[W] ? diff_neg[W-1:0] : diff_in[W-1:0];
                    bypass_next = ~above_tol;
                    last_next   = s_last_element;
                    state_next  = above_tol ? ST_SQRT : ST_FINISH;
                end
            end
            ST_SQRT: begin
                if (sq_st.done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (dv_st.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (load_out) begin
                    max_next   = last_reg ? '0 : max_upd;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg & ~m_ready;
        out_score_next = out_score_reg;
        out_max_next   = out_max_reg;
        out_last_next  = out_last_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
            out_score_next = score_val;
            out_max_next   = max_upd;
            out_last_next  = last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        bypass_reg    <= bypass_next;
        last_reg      <= last_next;
        out_score_reg <= out_score_next;
        out_max_reg   <= out_max_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid           = out_valid_reg;
    assign m_score           = out_score_reg;
    assign m_running_max_abs = out_max_reg;
    assign m_last_result     = out_last_reg;

    // the two arithmetic units never run at once
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sq_st.busy && dv_st.busy))
        else $error("square root and divider busy together");

    // root hand-over starts the divider straight away
    a_sqrt_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_st.done |=> dv_st.busy)
        else $error("divider not started after square root");

    // no arithmetic left running while a new element may be taken
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!sq_st.busy && !dv_st.busy))
        else $error("unit busy while idle");

    // the vector maximum is cleared after the last element
    a_max_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && last_reg) |=> (max_reg == '0))
        else $error("running maximum not cleared after last element");

endmodule

/* verif/smas_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smas_tb_pkg
// Register map and result layout shared by the standardized max-abs
// statistic testbench and its checker.
// ----------------------------------------------------------------------------
package smas_tb_pkg;

    localparam int SMAS_WIDTH = 32;
    localparam int SMAS_FRAC  = 16;

    // register index; byte address is 4 * index
    typedef enum logic [0:0] {
        REG_VARIANCE_TOLERANCE = 1'b0,
        REG_ABSOLUTE_MODE      = 1'b1
    } smas_reg_e;

    typedef struct packed {
        logic signed [SMAS_WIDTH-1:0] score;
        logic [SMAS_WIDTH-2:0]        running_max_abs;
        logic                         last_result;
    } score_result_t;

endpackage

/* verif/smas_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smas_checker
// Watches the element, result and register ports, predicts every score and
// running maximum, compares each result in order and checks register reads.
// ----------------------------------------------------------------------------
module smas_checker
    import smas_tb_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic signed [SMAS_WIDTH-1:0] s_statistic,
    input  logic signed [SMAS_WIDTH-1:0] s_expectation,
    input  logic [SMAS_WIDTH-1:0]        s_variance,
    input  logic                         s_last_element,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic signed [SMAS_WIDTH-1:0] m_score,
    input  logic [SMAS_WIDTH-2:0]        m_running_max_abs,
    input  logic                         m_last_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready,
    output int                           mismatches,
    output int                           pending
);

    localparam logic [63:0] SIGN_BIT = 64'd1 << (SMAS_WIDTH - 1);
    localparam logic [63:0] POS_MAX  = SIGN_BIT - 64'd1;

    logic [SMAS_WIDTH-1:0] tolerance;
    logic                  abs_mode;
    logic [SMAS_WIDTH-2:0] peak_abs;
    score_result_t         expected_scores[$];
    score_result_t         got;
    score_result_t         want;
    logic [31:0]           readback;

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] seen,
                                   input logic [63:0] wanted);
        $display("MISMATCH at %0t: %s got %h, expected %h", $realtime, what, seen, wanted);
        mismatches++;
    endtask

    // floor(sqrt(x)), two bits per step
    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] probe;
        rem   = x;
        r     = 64'd0;
        probe = 64'd1 << 62;
        while (probe > rem) probe = probe >> 2;
        while (probe != 64'd0) begin
            if (rem >= r + probe) begin
                rem = rem - (r + probe);
                r   = (r >> 1) + probe;
            end else begin
                r = r >> 1;
            end
            probe = probe >> 2;
        end
        return r;
    endfunction

    // score of one element; updates the running peak
    function automatic score_result_t standardize(input logic signed [SMAS_WIDTH-1:0] stat_v,
                                                  input logic signed [SMAS_WIDTH-1:0] mean_v,
                                                  input logic [SMAS_WIDTH-1:0] spread_v,
                                                  input logic last_v);
        score_result_t         res;
        logic signed [SMAS_WIDTH:0] diff;
        logic [SMAS_WIDTH:0]   abs_diff;
        logic                  neg;
        logic [63:0]           root;
        logic [63:0]           quot;
        logic [63:0]           clipped;
        logic [63:0]           neg_mag;
        res.score = '0;
        if (spread_v > tolerance) begin
            diff     = $signed({stat_v[SMAS_WIDTH-1], stat_v}) -
                       $signed({mean_v[SMAS_WIDTH-1], mean_v});
            neg      = diff[SMAS_WIDTH];
            abs_diff = neg ? -diff : diff;
            root     = root_floor({{(64-SMAS_WIDTH){1'b0}}, spread_v} << SMAS_FRAC);
            if (root == 64'd0)
                quot = SIGN_BIT;
            else
                quot = ({{(63-SMAS_WIDTH){1'b0}}, abs_diff} << SMAS_FRAC) / root;
            clipped = (quot > POS_MAX) ? POS_MAX : quot;
            neg_mag = (quot > SIGN_BIT) ? SIGN_BIT : quot;
            if (abs_mode || !neg)
                res.score = clipped[SMAS_WIDTH-1:0];
            else
                res.score = SMAS_WIDTH'(64'd0 - neg_mag);
            if (clipped[SMAS_WIDTH-2:0] > peak_abs)
                peak_abs = clipped[SMAS_WIDTH-2:0];
        end
        res.running_max_abs = peak_abs;
        res.last_result     = last_v;
        if (last_v)
            peak_abs = '0;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            tolerance = '0;
            abs_mode  = 1'b0;
            peak_abs  = '0;
            expected_scores.delete();
            pending   <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_score, m_running_max_abs, m_last_result};
                if (expected_scores.size() == 0) begin
                    report_mismatch("result with nothing pending, score", got.score, 0);
                end else begin
                    want = expected_scores.pop_front();
                    if (got.score !== want.score)
                        report_mismatch("score", got.score, want.score);
                    if (got.running_max_abs !== want.running_max_abs)
                        report_mismatch("running_max_abs", got.running_max_abs,
                                        want.running_max_abs);
                    if (got.last_result !== want.last_result)
                        report_mismatch("last_result", got.last_result, want.last_result);
                end
            end
            if (s_valid && s_ready)
                expected_scores.push_back(standardize(s_statistic, s_expectation,
                                                      s_variance, s_last_element));
            // register traffic only happens while the datapath is idle
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (smas_reg_e'(paddr[2]))
                        REG_VARIANCE_TOLERANCE: tolerance = pwdata[SMAS_WIDTH-1:0];
                        REG_ABSOLUTE_MODE:      abs_mode  = pwdata[0];
                        default: ;
                    endcase
                end else begin
                    case (smas_reg_e'(paddr[2]))
                        REG_VARIANCE_TOLERANCE: readback = tolerance;
                        REG_ABSOLUTE_MODE:      readback = {31'd0, abs_mode};
                        default:                readback = '0;
                    endcase
                    if (prdata !== readback)
                        report_mismatch("register readback", prdata, readback);
                end
            end
            pending <= expected_scores.size();
        end
    end

endmodule

/* verif/standardized_max_abs_statistic_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// standardized_max_abs_statistic_top_tb
// Drives element transactions and register accesses into the standardized
// max-abs statistic block under randomised idling and back-pressure; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module standardized_max_abs_statistic_top_tb;
    import smas_tb_pkg::*;

    localparam int ITEMS_PER_PHASE = 190;
    localparam int PHASES          = 8;
    localparam int LONG_HOLD       = 400;
    localparam int STALL_LIMIT     = 4000;
    localparam int END_SETTLE      = 100;

    logic                         aclk              = 1'b0;
    logic                         aresetn           = 1'b0;
    logic                         s_valid           = 1'b0;
    logic                         s_ready;
    logic signed [SMAS_WIDTH-1:0] s_statistic       = '0;
    logic signed [SMAS_WIDTH-1:0] s_expectation     = '0;
    logic [SMAS_WIDTH-1:0]        s_variance        = '0;
    logic                         s_last_element    = 1'b0;
    logic                         m_valid;
    logic                         m_ready           = 1'b0;
    logic signed [SMAS_WIDTH-1:0] m_score;
    logic [SMAS_WIDTH-2:0]        m_running_max_abs;
    logic                         m_last_result;
    logic                         psel              = 1'b0;
    logic                         penable           = 1'b0;
    logic                         pwrite            = 1'b0;
    logic [2:0]                   paddr             = '0;
    logic [31:0]                  pwdata            = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    int mismatches;
    int pending;
    int stall_cycles    = 0;
    int elements_in     = 0;
    int results_out     = 0;
    int settings_used   = 0;
    bit tx_idle         = 1'b1;
    bit rx_idle         = 1'b1;
    bit long_hold_req   = 1'b0;

    always #5 aclk = ~aclk;

    standardized_max_abs_statistic_top #(
        .DATA_WIDTH(SMAS_WIDTH),
        .FRAC_BITS (SMAS_FRAC)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_statistic      (s_statistic),
        .s_expectation    (s_expectation),
        .s_variance       (s_variance),
        .s_last_element   (s_last_element),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_score          (m_score),
        .m_running_max_abs(m_running_max_abs),
        .m_last_result    (m_last_result),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    smas_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_statistic      (s_statistic),
        .s_expectation    (s_expectation),
        .s_variance       (s_variance),
        .s_last_element   (s_last_element),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_score          (m_score),
        .m_running_max_abs(m_running_max_abs),
        .m_last_result    (m_last_result),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .mismatches       (mismatches),
        .pending          (pending)
    );

    // one element transaction; returns at the edge that accepts it
    task automatic send_element(input logic [31:0] stat_v, input logic [31:0] mean_v,
                                input logic [31:0] spread_v, input logic last_v);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_statistic    <= stat_v;
        s_expectation  <= mean_v;
        s_variance     <= spread_v;
        s_last_element <= last_v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // setup then access phase
    task automatic apb_access(input logic wr, input smas_reg_e idx, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_registers(input logic [31:0] tol_v, input logic mode_v);
        logic [31:0] junk;
        junk = $urandom;
        apb_access(1'b1, REG_VARIANCE_TOLERANCE, tol_v);
        apb_access(1'b0, REG_VARIANCE_TOLERANCE, '0);
        // upper bits of the mode register must be ignored
        apb_access(1'b1, REG_ABSOLUTE_MODE, {junk[31:1], mode_v});
        apb_access(1'b0, REG_ABSOLUTE_MODE, '0);
        settings_used++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    initial begin : rx_side
        int gap;
        forever begin
            gap = rx_idle ? $urandom_range(0, 15) : 0;
            if (long_hold_req) begin
                gap           = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) elements_in++;
            if (m_valid && m_ready) results_out++;
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int          phase;
        int          sent;
        int          vec_len;
        int          k;
        int          pick;
        logic [31:0] cur_tol;
        logic        cur_mode;
        logic [31:0] stat_v;
        logic [31:0] mean_v;
        logic [31:0] spread_v;
        logic        last_v;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: zero tolerance, signed scores
        send_element(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_element(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
        send_element(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        // exactly the most negative score, no clipping needed
        send_element(32'hFF80_0000, 32'h0000_0000, 32'h0000_0001, 1'b0);
        send_element(32'h0080_0000, 32'h0000_0000, 32'h0000_0001, 1'b1);
        send_element(32'h0003_8000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        send_element(32'hFFFE_0000, 32'h0000_0000, 32'h0004_0000, 1'b0);
        send_element(32'h1234_5678, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
        // variance at tolerance: peak must hold
        send_element(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_element(32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_element(32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 1'b1);
        drain(8);

        set_registers(32'h0001_0000, 1'b1);
        send_element(32'h0005_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
        send_element(32'h0005_0000, 32'h0000_0000, 32'h0001_0001, 1'b0);
        send_element(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        send_element(32'hFFFB_0000, 32'h0000_0000, 32'h0009_0000, 1'b0);
        send_element(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_element(32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0001, 1'b1);
        drain(8);

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       begin cur_tol = 32'h0000_0000; cur_mode = 1'b0; end
                1:       begin cur_tol = 32'h0000_0000; cur_mode = 1'b1; end
                2:       begin cur_tol = 32'hFFFF_FFFF; cur_mode = 1'b0; end
                3:       begin cur_tol = 32'hFFFF_FFFE; cur_mode = 1'b1; end
                4:       begin cur_tol = $urandom; cur_mode = 1'($urandom_range(0, 1)); end
                5:       begin cur_tol = $urandom_range(0, 32'h00FF_FFFF); cur_mode = 1'b0; end
                6:       begin cur_tol = 32'h0001_0000; cur_mode = 1'b1; end
                default: begin cur_tol = $urandom; cur_mode = 1'b0; end
            endcase
            set_registers(cur_tol, cur_mode);
            tx_idle       = (phase % 4 == 0) || (phase % 4 == 1);
            rx_idle       = (phase % 4 == 0) || (phase % 4 == 2);
            long_hold_req = (phase == 1) || (phase == 5);

            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                vec_len = $urandom_range(1, 12);
                for (k = 0; k < vec_len && sent < ITEMS_PER_PHASE; k++) begin
                    pick = $urandom_range(0, 7);
                    if (pick < 2) begin
                        stat_v = $urandom;
                        mean_v = $urandom;
                    end else if (pick == 2) begin
                        stat_v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                        mean_v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    end else begin
                        mean_v = $urandom;
                        stat_v = mean_v + $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
                    end
                    pick = $urandom_range(0, 9);
                    case (pick)
                        0, 1, 2: spread_v = $urandom;
                        3, 4:    spread_v = $urandom_range(1, 255);
                        5, 6:    spread_v = cur_tol + $urandom_range(0, 4) - 32'd2;
                        7:       spread_v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                        default: spread_v = $urandom_range(32'h0001_0000, 32'h0100_0000);
                    endcase
                    last_v = (k == vec_len - 1);
                    // occasional stray vector marks
                    if ($urandom_range(0, 9) == 0)
                        last_v = 1'($urandom_range(0, 1));
                    send_element(stat_v, mean_v, spread_v, last_v);
                    sent++;
                end
            end
            drain(8);
        end

        drain(END_SETTLE);
        $display("Summary: %0d elements, %0d results, %0d register settings after reset",
                 elements_in, results_out, settings_used);
        $display("Covered sub-tolerance variances, clipping both ways, both score modes, "
                 , "vector ends and long output back-pressure");
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/smas_pkg.sv
sv/smas_cfg.sv
sv/smas_isqrt.sv
sv/smas_divider.sv
sv/standardized_max_abs_statistic_top.sv
verif/smas_tb_pkg.sv
verif/smas_checker.sv
verif/standardized_max_abs_statistic_top_tb.sv
